// ----- rtl/cal_pkg.sv -----
// ----------------------------------------------------------------------------
// cal_pkg
// Shared constants, codes and control types for the cursor array list.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int CAL_DEPTH = 64;
    localparam int CAL_WIDTH = 32;
    localparam int CAL_AW    = $clog2(CAL_DEPTH);
    localparam int CAL_CW    = 7;
    localparam int CAL_OPW   = 4;
    localparam int CAL_STW   = 2;

    localparam logic [CAL_CW-1:0] CAL_CAP_RESET = CAL_CW'(64);

    typedef enum logic [CAL_OPW-1:0] {
        OP_CLEAR  = 4'd0,
        OP_INSERT = 4'd1,
        OP_APPEND = 4'd2,
        OP_REMOVE = 4'd3,
        OP_START  = 4'd4,
        OP_END    = 4'd5,
        OP_NEXT   = 4'd6,
        OP_PREV   = 4'd7,
        OP_SEEK   = 4'd8,
        OP_READ   = 4'd9
    } t_op;

    typedef enum logic [CAL_STW-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_LOOP,
        S_INS_WR,
        S_REM_GET,
        S_REM_LOOP,
        S_REM_WR,
        S_RD_GET,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {RA_CURSOR, RA_IDX_DN, RA_IDX_UP} t_rd_addr;
    typedef enum logic [1:0] {WA_IDX_SHIFT, WA_COUNT_VAL, WA_CURSOR_VAL} t_wr_sel;
    typedef enum logic [1:0] {CN_HOLD, CN_CLEAR, CN_INC, CN_DEC} t_cnt_op;
    typedef enum logic [2:0] {CU_HOLD, CU_ZERO, CU_END, CU_NEXT, CU_PREV, CU_SEEK} t_cur_op;
    typedef enum logic [2:0] {IX_HOLD, IX_COUNT, IX_CURSOR, IX_DEC, IX_INC} t_idx_op;

    typedef struct packed {
        logic     latch;
        logic     start;
        t_status  status;
        logic     rd_en;
        t_rd_addr rd_addr;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_cnt_op  cnt_op;
        t_cur_op  cur_op;
        t_idx_op  idx_op;
        logic     take_data;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [CAL_OPW-1:0] op;
        logic               full;
        logic               ins_range;
        logic               acc_range;
        logic               seek_range;
        logic               idx_above_cur;
        logic               idx_next_in;
        logic               out_busy;
    } t_dp_stat;

endpackage

// ----- rtl/cal_ram.sv -----
// ----------------------------------------------------------------------------
// cal_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cal_ctrl.sv -----
// ----------------------------------------------------------------------------
// cal_ctrl
// Command sequencer: decodes a request and steps the datapath through
// shifts, reads and the result hand-off.
// ----------------------------------------------------------------------------
module cal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cal_pkg::t_dp_stat i_stat,
    output cal_pkg::t_dp_cmd  o_cmd
);
    import cal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_cmd.latch     = 1'b0;
        o_cmd.start     = 1'b0;
        o_cmd.status    = ST_OK;
        o_cmd.rd_en     = 1'b0;
        o_cmd.rd_addr   = RA_CURSOR;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_sel    = WA_IDX_SHIFT;
        o_cmd.cnt_op    = CN_HOLD;
        o_cmd.cur_op    = CU_HOLD;
        o_cmd.idx_op    = IX_HOLD;
        o_cmd.take_data = 1'b0;
        o_cmd.load_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.start = 1'b1;
                n_state     = S_FINISH;
                unique case (i_stat.op)
                    OP_CLEAR: o_cmd.cnt_op = CN_CLEAR;
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (i_stat.ins_range) begin
                            o_cmd.status = ST_RANGE;
                        end else begin
                            o_cmd.idx_op = IX_COUNT;
                            n_state      = S_INS_LOOP;
                        end
                    end
                    OP_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WA_COUNT_VAL;
                            o_cmd.cnt_op = CN_INC;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.acc_range) begin
                            o_cmd.status = ST_RANGE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = RA_CURSOR;
                            o_cmd.idx_op  = IX_CURSOR;
                            n_state       = S_REM_GET;
                        end
                    end
                    OP_START: o_cmd.cur_op = CU_ZERO;
                    OP_END:   o_cmd.cur_op = CU_END;
                    OP_NEXT:  o_cmd.cur_op = CU_NEXT;
                    OP_PREV:  o_cmd.cur_op = CU_PREV;
                    OP_SEEK: begin
                        if (i_stat.seek_range) begin
                            o_cmd.status = ST_RANGE;
                        end else begin
                            o_cmd.cur_op = CU_SEEK;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.acc_range) begin
                            o_cmd.status = ST_RANGE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = RA_CURSOR;
                            n_state       = S_RD_GET;
                        end
                    end
                    default: o_cmd.status = ST_OK;
                endcase
            end
            S_INS_LOOP: begin
                if (i_stat.idx_above_cur) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_IDX_DN;
                    n_state       = S_INS_WR;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WA_CURSOR_VAL;
                    o_cmd.cnt_op = CN_INC;
                    n_state      = S_FINISH;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_IDX_SHIFT;
                o_cmd.idx_op = IX_DEC;
                n_state      = S_INS_LOOP;
            end
            S_REM_GET: begin
                o_cmd.take_data = 1'b1;
                n_state         = S_REM_LOOP;
            end
            S_REM_LOOP: begin
                if (i_stat.idx_next_in) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = RA_IDX_UP;
                    n_state       = S_REM_WR;
                end else begin
                    o_cmd.cnt_op = CN_DEC;
                    n_state      = S_FINISH;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WA_IDX_SHIFT;
                o_cmd.idx_op = IX_INC;
                n_state      = S_REM_LOOP;
            end
            S_RD_GET: begin
                o_cmd.take_data = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/cal_dp.sv -----
// ----------------------------------------------------------------------------
// cal_dp
// Datapath: request registers, length, cursor, capacity, shift index,
// entry RAM and the result register.
// ----------------------------------------------------------------------------
module cal_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cal_pkg::CAL_OPW-1:0]     i_command,
    input  logic [cal_pkg::CAL_WIDTH-1:0]   i_value,
    input  logic [cal_pkg::CAL_CW-1:0]      i_position,
    input  logic                            i_cfg_we,
    input  logic [cal_pkg::CAL_CW-1:0]      i_cfg_data,
    input  cal_pkg::t_dp_cmd                i_cmd,
    output cal_pkg::t_dp_stat               o_stat,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [cal_pkg::CAL_WIDTH-1:0]   o_data,
    output logic [cal_pkg::CAL_CW-1:0]      o_length,
    output logic [cal_pkg::CAL_CW-1:0]      o_cursor,
    output logic [cal_pkg::CAL_STW-1:0]     o_status
);
    import cal_pkg::*;

    localparam logic [CAL_CW-1:0] DEPTH_W = CAL_CW'(CAL_DEPTH);
    localparam logic [CAL_CW-1:0] ONE_W   = CAL_CW'(1);

    logic [CAL_OPW-1:0]   r_op;
    logic [CAL_WIDTH-1:0] r_val;
    logic [CAL_CW-1:0]    r_pos;
    logic [CAL_CW-1:0]    r_cap;
    logic [CAL_CW-1:0]    r_count;
    logic [CAL_CW-1:0]    r_cursor;
    logic [CAL_CW-1:0]    r_idx;
    logic [CAL_WIDTH-1:0] r_data;
    t_status              r_status;
    logic                 r_o_valid;
    logic [CAL_WIDTH-1:0] r_o_data;
    logic [CAL_CW-1:0]    r_o_length;
    logic [CAL_CW-1:0]    r_o_cursor;
    t_status              r_o_status;

    logic [CAL_CW-1:0]    limit;
    logic [CAL_CW-1:0]    idx_dn;
    logic [CAL_CW-1:0]    idx_up;
    logic                 ram_we;
    logic [CAL_AW-1:0]    ram_waddr;
    logic [CAL_WIDTH-1:0] ram_wdata;
    logic [CAL_AW-1:0]    ram_raddr;
    logic [CAL_WIDTH-1:0] ram_rdata;

    assign limit  = (r_cap >= DEPTH_W) ? DEPTH_W : r_cap;
    assign idx_dn = r_idx - ONE_W;
    assign idx_up = r_idx + ONE_W;

    assign o_stat.op            = r_op;
    assign o_stat.full          = (r_count >= limit);
    assign o_stat.ins_range     = (r_cursor > r_count);
    assign o_stat.acc_range     = (r_cursor >= r_count);
    assign o_stat.seek_range    = (r_pos > r_count);
    assign o_stat.idx_above_cur = (r_idx > r_cursor);
    assign o_stat.idx_next_in   = (idx_up < r_count);
    assign o_stat.out_busy      = r_o_valid && !i_ready;

    always_comb begin
        ram_we    = i_cmd.wr_en;
        ram_waddr = r_idx[CAL_AW-1:0];
        ram_wdata = ram_rdata;
        case (i_cmd.wr_sel)
            WA_COUNT_VAL: begin
                ram_waddr = r_count[CAL_AW-1:0];
                ram_wdata = r_val;
            end
            WA_CURSOR_VAL: begin
                ram_waddr = r_cursor[CAL_AW-1:0];
                ram_wdata = r_val;
            end
            default: begin
                ram_waddr = r_idx[CAL_AW-1:0];
                ram_wdata = ram_rdata;
            end
        endcase
        case (i_cmd.rd_addr)
            RA_IDX_DN: ram_raddr = idx_dn[CAL_AW-1:0];
            RA_IDX_UP: ram_raddr = idx_up[CAL_AW-1:0];
            default:   ram_raddr = r_cursor[CAL_AW-1:0];
        endcase
    end

    cal_ram #(
        .WIDTH (CAL_WIDTH),
        .DEPTH (CAL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_command;
            r_val <= i_value;
            r_pos <= i_position;
        end
        if (i_cmd.start) begin
            r_data   <= '0;
            r_status <= i_cmd.status;
        end else if (i_cmd.take_data) begin
            r_data <= ram_rdata;
        end
        case (i_cmd.idx_op)
            IX_COUNT:  r_idx <= r_count;
            IX_CURSOR: r_idx <= r_cursor;
            IX_DEC:    r_idx <= idx_dn;
            IX_INC:    r_idx <= idx_up;
            default:   r_idx <= r_idx;
        endcase
        if (i_cmd.load_out) begin
            r_o_data   <= r_data;
            r_o_length <= r_count;
            r_o_cursor <= r_cursor;
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAL_CAP_RESET;
            r_count   <= '0;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            case (i_cmd.cnt_op)
                CN_CLEAR: r_count <= '0;
                CN_INC:   r_count <= r_count + ONE_W;
                CN_DEC:   r_count <= r_count - ONE_W;
                default:  r_count <= r_count;
            endcase
            case (i_cmd.cur_op)
                CU_ZERO: r_cursor <= '0;
                CU_END:  r_cursor <= r_count;
                CU_NEXT: begin
                    if (r_cursor < r_count) begin
                        r_cursor <= r_cursor + ONE_W;
                    end
                end
                CU_PREV: begin
                    if (r_cursor != '0) begin
                        r_cursor <= r_cursor - ONE_W;
                    end
                end
                CU_SEEK: r_cursor <= r_pos;
                default: r_cursor <= r_cursor;
            endcase
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_data   = r_o_data;
    assign o_length = r_o_length;
    assign o_cursor = r_o_cursor;
    assign o_status = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_W)
        else $error("length beyond store depth");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_sel == WA_IDX_SHIFT) |-> (r_idx <= r_count))
        else $error("shift write outside list");

    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == CN_INC) |-> (r_count < limit))
        else $error("length grew past limit");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_o_valid)
        else $error("result not presented after load");

endmodule

// ----- rtl/cursor_array_list.sv -----
// ----------------------------------------------------------------------------
// cursor_array_list
// Ordered word list with length and cursor, held in a 64-entry RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_ready  | i_command, i_value, i_position
//  result  | out       | o_valid / i_ready  | o_data, o_length, o_cursor, o_status
//  config  | in        | i_cfg_we           | i_cfg_data (capacity)
//
//  Clear, append, cursor moves, unused codes and any rejected request go from
//  decode straight to the result; read adds a RAM read; insert and remove
//  shift the entries between cursor and length. Each shifted entry costs a
//  read and a write on the single RAM port pair.
//  Reset clears length, cursor and the result valid; capacity returns to 64.
//  A result held by a stalled consumer delays only the completion of the next
//  request, which is accepted and worked meanwhile.
// ----------------------------------------------------------------------------
module cursor_array_list (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cal_pkg::CAL_OPW-1:0]     i_command,
    input  logic [cal_pkg::CAL_WIDTH-1:0]   i_value,
    input  logic [cal_pkg::CAL_CW-1:0]      i_position,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cal_pkg::CAL_WIDTH-1:0]   o_data,
    output logic [cal_pkg::CAL_CW-1:0]      o_length,
    output logic [cal_pkg::CAL_CW-1:0]      o_cursor,
    output logic [cal_pkg::CAL_STW-1:0]     o_status,
    input  logic                            i_cfg_we,
    input  logic [cal_pkg::CAL_CW-1:0]      i_cfg_data
);
    import cal_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    cal_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .o_length   (o_length),
        .o_cursor   (o_cursor),
        .o_status   (o_status)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: cursor array list testbench
// Drives list commands through the request channel and checks every answer
// against a cycle-free predictor of the list, its length and its cursor, or
// the typed rows of the edge-case directed table; random phases sweep capacity.
// ----------------------------------------------------------------------------
module tb;
    import cal_pkg::*;

    localparam logic [CAL_OPW-1:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [CAL_OPW-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int PHASE_ITEMS = 180;
    localparam int N_PHASES    = 10;
    localparam int SETTLE      = 8;
    localparam logic [CAL_CW-1:0] CAP_PLAN [N_PHASES] =
        '{7'd64, 7'd8, 7'd1, 7'd127, 7'd0, 7'd64, 7'd33, 7'd2, 7'd64, 7'd100};

    typedef struct packed {
        logic [CAL_WIDTH-1:0] data;
        logic [CAL_CW-1:0]    length;
        logic [CAL_CW-1:0]    cursor;
        t_status              status;
    } t_list_res;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CAL_OPW-1:0]   cmd;
        logic [CAL_WIDTH-1:0] value;
        logic [CAL_CW-1:0]    arg;
        bit                   typed;
        t_list_res            want;
    } t_dir_row;

    localparam int N_ROWS = 30;
    localparam t_dir_row DIR_TAB [N_ROWS] = '{
        '{ROW_REQ, OP_READ,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{ROW_REQ, OP_REMOVE, 32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd0, ST_RANGE}},
        '{ROW_REQ, OP_APPEND, 32'hFFFFFFFF, 7'd127, 1'b1, '{32'h0, 7'd1, 7'd0, ST_OK}},
        '{ROW_REQ, OP_APPEND, 32'h0,        7'd0,   1'b1, '{32'h0, 7'd2, 7'd0, ST_OK}},
        '{ROW_REQ, OP_INSERT, 32'hA5A5A5A5, 7'd0,   1'b1, '{32'h0, 7'd3, 7'd0, ST_OK}},
        '{ROW_REQ, OP_SEEK,   32'h0,        7'd3,   1'b1, '{32'h0, 7'd3, 7'd3, ST_OK}},
        '{ROW_REQ, OP_SEEK,   32'h0,        7'd127, 1'b1, '{32'h0, 7'd3, 7'd3, ST_RANGE}},
        '{ROW_REQ, OP_NEXT,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd3, ST_OK}},
        '{ROW_REQ, OP_READ,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd3, ST_RANGE}},
        '{ROW_REQ, OP_PREV,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd2, ST_OK}},
        '{ROW_REQ, OP_START,  32'h0,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd0, ST_OK}},
        '{ROW_REQ, OP_PREV,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd0, ST_OK}},
        '{ROW_REQ, OP_READ,   32'h0,        7'd0,   1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_CFG, OP_CLEAR,  32'h0,        7'd3,   1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_REQ, OP_APPEND, 32'h1,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd0, ST_FULL}},
        '{ROW_REQ, OP_INSERT, 32'h2,        7'd0,   1'b1, '{32'h0, 7'd3, 7'd0, ST_FULL}},
        '{ROW_REQ, OP_REMOVE, 32'h0,        7'd0,   1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_CFG, OP_CLEAR,  32'h0,        7'd0,   1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_REQ, OP_APPEND, 32'h3,        7'd0,   1'b1, '{32'h0, 7'd2, 7'd0, ST_FULL}},
        '{ROW_CFG, OP_CLEAR,  32'h0,        7'd127, 1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_REQ, OP_END,    32'h0,        7'd0,   1'b1, '{32'h0, 7'd2, 7'd2, ST_OK}},
        '{ROW_REQ, OP_CLEAR,  32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd2, ST_OK}},
        '{ROW_REQ, OP_INSERT, 32'h4,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd2, ST_RANGE}},
        '{ROW_REQ, OP_REMOVE, 32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd2, ST_RANGE}},
        '{ROW_REQ, CMD_UNUSED_LO, 32'hFFFFFFFF, 7'd127, 1'b1, '{32'h0, 7'd0, 7'd2, ST_OK}},
        '{ROW_REQ, CMD_UNUSED_HI, 32'h0,    7'd0,   1'b1, '{32'h0, 7'd0, 7'd2, ST_OK}},
        '{ROW_REQ, OP_NEXT,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd2, ST_OK}},
        '{ROW_REQ, OP_SEEK,   32'h0,        7'd0,   1'b1, '{32'h0, 7'd0, 7'd0, ST_OK}},
        '{ROW_REQ, OP_INSERT, 32'h5A5A5A5A, 7'd0,   1'b1, '{32'h0, 7'd1, 7'd0, ST_OK}},
        '{ROW_REQ, OP_READ,   32'h0,        7'd0,   1'b0, '{32'h0, 7'd0, 7'd0, ST_OK}}
    };

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic [CAL_OPW-1:0]   i_command  = '0;
    logic [CAL_WIDTH-1:0] i_value    = '0;
    logic [CAL_CW-1:0]    i_position = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [CAL_WIDTH-1:0] o_data;
    logic [CAL_CW-1:0]    o_length;
    logic [CAL_CW-1:0]    o_cursor;
    logic [CAL_STW-1:0]   o_status;
    logic                 i_cfg_we   = 1'b0;
    logic [CAL_CW-1:0]    i_cfg_data = '0;

    cursor_array_list dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_value    (i_value),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .o_length   (o_length),
        .o_cursor   (o_cursor),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // shadow list
    logic [CAL_WIDTH-1:0] shadow_cells [CAL_DEPTH];
    int                   shadow_len = 0;
    int                   shadow_cur = 0;
    int                   shadow_cap = 64;

    t_list_res expected_results [$];
    t_list_res want;
    bit        quiet_run = 1'b0;
    int        err_cnt   = 0;
    int        sent_cnt  = 0;
    int        full_seen = 0;
    int        range_seen = 0;
    int        longest_len = 0;

    function automatic t_list_res list_step(input logic [CAL_OPW-1:0] cmd,
                                            input logic [CAL_WIDTH-1:0] val,
                                            input logic [CAL_CW-1:0] pos);
        t_list_res res;
        int        lim;
        lim = (shadow_cap < CAL_DEPTH) ? shadow_cap : CAL_DEPTH;
        res = '{'0, '0, '0, ST_OK};
        case (cmd)
            OP_CLEAR: shadow_len = 0;
            OP_INSERT: begin
                if (shadow_len >= lim) begin
                    res.status = ST_FULL;
                end else if (shadow_cur > shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = shadow_len; i > shadow_cur; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[shadow_cur] = val;
                    shadow_len++;
                end
            end
            OP_APPEND: begin
                if (shadow_len >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_cells[shadow_len] = val;
                    shadow_len++;
                end
            end
            OP_REMOVE: begin
                if (shadow_cur >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = shadow_cells[shadow_cur];
                    for (int i = shadow_cur; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
            end
            OP_START: shadow_cur = 0;
            OP_END:   shadow_cur = shadow_len;
            OP_NEXT: begin
                if (shadow_cur < shadow_len) shadow_cur++;
            end
            OP_PREV: begin
                if (shadow_cur != 0) shadow_cur--;
            end
            OP_SEEK: begin
                if (int'(pos) <= shadow_len) shadow_cur = int'(pos);
                else res.status = ST_RANGE;
            end
            OP_READ: begin
                if (shadow_cur >= shadow_len) res.status = ST_RANGE;
                else res.data = shadow_cells[shadow_cur];
            end
            default: ;
        endcase
        res.length = CAL_CW'(shadow_len);
        res.cursor = CAL_CW'(shadow_cur);
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= quiet_run || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (o_status == ST_FULL)  full_seen++;
            if (o_status == ST_RANGE) range_seen++;
            if (int'(o_length) > longest_len) longest_len = int'(o_length);
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                err_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (o_data !== want.data) begin
                    $error("data: expected %h, got %h", want.data, o_data);
                    err_cnt++;
                end
                if (o_length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_length);
                    err_cnt++;
                end
                if (o_cursor !== want.cursor) begin
                    $error("cursor: expected %0d, got %0d", want.cursor, o_cursor);
                    err_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_request(input logic [CAL_OPW-1:0] cmd,
                                input logic [CAL_WIDTH-1:0] val,
                                input logic [CAL_CW-1:0] pos,
                                input bit typed,
                                input t_list_res typed_res);
        t_list_res pred;
        while (!quiet_run && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        pred = list_step(cmd, val, pos);
        expected_results.push_back(typed ? typed_res : pred);
        sent_cnt++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAL_CW-1:0] cap);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_cap = int'(cap);
    endtask

    initial begin
        logic [CAL_OPW-1:0]   rc;
        logic [CAL_WIDTH-1:0] rv;
        logic [CAL_CW-1:0]    rp;
        int                   w;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[r]) begin
            if (DIR_TAB[r].kind == ROW_CFG) begin
                drain();
                write_capacity(DIR_TAB[r].arg);
            end else begin
                push_request(DIR_TAB[r].cmd, DIR_TAB[r].value, DIR_TAB[r].arg,
                             DIR_TAB[r].typed, DIR_TAB[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_capacity(CAP_PLAN[ph]);
            quiet_run = (ph == 5);
            repeat (PHASE_ITEMS) begin
                w = $urandom_range(0, 99);
                if (w < 22)      rc = OP_INSERT;
                else if (w < 42) rc = OP_APPEND;
                else if (w < 56) rc = OP_REMOVE;
                else if (w < 68) rc = OP_READ;
                else if (w < 72) rc = OP_START;
                else if (w < 76) rc = OP_END;
                else if (w < 83) rc = OP_NEXT;
                else if (w < 89) rc = OP_PREV;
                else if (w < 97) rc = OP_SEEK;
                else if (w < 98) rc = OP_CLEAR;
                else             rc = CAL_OPW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                case ($urandom_range(0, 15))
                    0:       rv = '0;
                    1:       rv = '1;
                    default: rv = $urandom;
                endcase
                if (rc == OP_SEEK && $urandom_range(0, 3) != 0)
                    rp = CAL_CW'($urandom_range(0, shadow_len));
                else
                    rp = CAL_CW'($urandom_range(0, 127));
                push_request(rc, rv, rp, 1'b0, '0);
            end
        end
        quiet_run = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests across %0d capacity settings, 0 through 127",
                 sent_cnt, N_PHASES + 3);
        $display("answers: %0d full, %0d out of range; longest list %0d entries",
                 full_seen, range_seen, longest_len);
        if (err_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
